// File: sv/fenv_pkg.sv
// Shared types, widths and the control program of the fade envelope unit.
// Used by fade_envelope_with_min_hold_unit; depends on nothing else.
package fenv_pkg;

   localparam int TIME_BITS  = 24;
   localparam int LEVEL_BITS = 16;
   localparam int DT_BITS    = 16;

   localparam int CNT_BITS  = ((TIME_BITS > DT_BITS) ? TIME_BITS : DT_BITS) + 2;
   localparam int DIV_BITS  = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;
   localparam int ITER_BITS = $clog2(DIV_BITS);
   localparam int REQ_BITS  = ((DT_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_BITS  = ((LEVEL_BITS + 3 + 7) / 8) * 8;
   localparam int CSR_IDX_BITS = 2;
   localparam int PC_BITS   = 4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RISE_TIME = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FALL_TIME = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_HOLD  = 2'd2;

   typedef enum logic [1:0] {
      PH_OFF  = 2'd0,
      PH_RISE = 2'd1,
      PH_ON   = 2'd2,
      PH_FALL = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_STEP,
      OP_MUL,
      OP_RLOAD,
      OP_DIV,
      OP_RSET,
      OP_LLOAD,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      CD_NEVER,
      CD_ALWAYS,
      CD_NO_REQ,
      CD_NO_RESCALE,
      CD_ITER_MORE,
      CD_RSP_BUSY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_BITS-1:0]  target;
   } uword_type;

   localparam logic [PC_BITS-1:0] PC_WAIT  = 4'd0;
   localparam logic [PC_BITS-1:0] PC_STEP  = 4'd1;
   localparam logic [PC_BITS-1:0] PC_MUL   = 4'd2;
   localparam logic [PC_BITS-1:0] PC_RLOAD = 4'd3;
   localparam logic [PC_BITS-1:0] PC_RDIV  = 4'd4;
   localparam logic [PC_BITS-1:0] PC_RSET  = 4'd5;
   localparam logic [PC_BITS-1:0] PC_LLOAD = 4'd6;
   localparam logic [PC_BITS-1:0] PC_LDIV  = 4'd7;
   localparam logic [PC_BITS-1:0] PC_EMIT  = 4'd8;
   localparam logic [PC_BITS-1:0] PC_RET   = 4'd9;

   // jump to target when cond holds, else fall through
   function automatic uword_type ucode_rom(input logic [PC_BITS-1:0] addr);
      uword_type w;
      begin
         unique case (addr)
            PC_WAIT:  w = '{op: OP_NOP,   cond: CD_NO_REQ,     target: PC_WAIT};
            PC_STEP:  w = '{op: OP_STEP,  cond: CD_NO_RESCALE, target: PC_LLOAD};
            PC_MUL:   w = '{op: OP_MUL,   cond: CD_NEVER,      target: PC_WAIT};
            PC_RLOAD: w = '{op: OP_RLOAD, cond: CD_NEVER,      target: PC_WAIT};
            PC_RDIV:  w = '{op: OP_DIV,   cond: CD_ITER_MORE,  target: PC_RDIV};
            PC_RSET:  w = '{op: OP_RSET,  cond: CD_NEVER,      target: PC_WAIT};
            PC_LLOAD: w = '{op: OP_LLOAD, cond: CD_NEVER,      target: PC_WAIT};
            PC_LDIV:  w = '{op: OP_DIV,   cond: CD_ITER_MORE,  target: PC_LDIV};
            PC_EMIT:  w = '{op: OP_EMIT,  cond: CD_RSP_BUSY,   target: PC_EMIT};
            PC_RET:   w = '{op: OP_NOP,   cond: CD_ALWAYS,     target: PC_WAIT};
            default:  w = '{op: OP_NOP,   cond: CD_ALWAYS,     target: PC_WAIT};
         endcase
         return w;
      end
   endfunction

endpackage

// File: sv/fade_envelope_with_min_hold_unit.sv
// Attack-hold-release envelope with minimum hold, run by a small microcode sequencer.
// Depends on fenv_pkg for widths, phase codes and the control program.

// One tick is taken at a time; the unit is ready for the next one once the result
// of the last has gone into the output register, which waits while an earlier
// result is still unread. The work is done by the shared shift-and-subtract
// divider, which makes one quotient bit per cycle: once for the output level and,
// on a tick on which enable reverses a running ramp, once more after a multiply
// to rescale the time count to the other ramp. The result sits in an output
// register, so the next tick is taken while it waits to be read.
// Configuration writes are always accepted and must arrive while idle.
module fade_envelope_with_min_hold_unit
   import fenv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_BITS-1:0]      req_tdata,   // elapsed, enable
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_BITS-1:0]      rsp_tdata,   // level, phase_now, is_off
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [TIME_BITS-1:0]     csr_data
);

   localparam int LO_SHIFT = DIV_BITS - TIME_BITS;

   logic [PC_BITS-1:0]          pc_ff, pc_in;
   phase_type                   phase_ff, phase_in;
   logic signed [CNT_BITS-1:0]  count_ff, count_in;
   logic [TIME_BITS-1:0]        rise_ff, rise_in, fall_ff, fall_in, hold_ff, hold_in;
   logic [DT_BITS-1:0]          dt_ff, dt_in;
   logic                        en_ff, en_in;
   logic [2*TIME_BITS-1:0]      prod_ff, prod_in;
   logic [TIME_BITS-1:0]        rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DIV_BITS-1:0]         lo_ff, lo_in;
   logic [ITER_BITS-1:0]        iter_ff, iter_in;
   logic                        sat_ff, sat_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0]       rsp_level_ff, rsp_level_in;
   phase_type                   rsp_phase_ff, rsp_phase_in;

   uword_type                   uw;
   logic                        jump;
   logic                        req_fire, rsp_busy, rescale;
   logic [TIME_BITS-1:0]        rl, fl, from_len, to_len, cur_len, clamp_from, clamp_cur;
   logic signed [CNT_BITS-1:0]  dt_s, rl_s, cnt_base, sum_c, diff_c;
   logic [TIME_BITS:0]          div_t, div_sub;
   logic                        div_ge;

   function automatic logic [TIME_BITS-1:0] clamp_cnt(
      input logic signed [CNT_BITS-1:0] c,
      input logic [TIME_BITS-1:0]       len
   );
      logic [TIME_BITS-1:0] r;
      begin
         if (c[CNT_BITS-1]) begin
            r = '0;
         end else if (c > $signed(CNT_BITS'(len))) begin
            r = len;
         end else begin
            r = c[TIME_BITS-1:0];
         end
         return r;
      end
   endfunction

   assign uw         = ucode_rom(pc_ff);
   assign req_tready = (pc_ff == PC_WAIT);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_busy   = rsp_valid_ff && !rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({(rsp_phase_ff == PH_OFF), rsp_phase_ff, rsp_level_ff});

   assign rl       = (rise_ff == '0) ? TIME_BITS'(1) : rise_ff;
   assign fl       = (fall_ff == '0) ? TIME_BITS'(1) : fall_ff;
   assign rescale  = ((phase_ff == PH_RISE) && !en_ff) || ((phase_ff == PH_FALL) && en_ff);
   assign from_len = (phase_ff == PH_RISE) ? rl : fl;
   assign to_len   = (phase_ff == PH_RISE) ? fl : rl;
   assign cur_len  = from_len;
   assign clamp_from = clamp_cnt(count_ff, from_len);
   assign clamp_cur  = clamp_cnt(count_ff, cur_len);

   assign dt_s     = $signed(CNT_BITS'(dt_ff));
   assign rl_s     = $signed(CNT_BITS'(rl));
   assign cnt_base = (phase_ff == PH_OFF) ? '0 : count_ff;
   assign sum_c    = cnt_base + dt_s;
   assign diff_c   = count_ff - dt_s;

   assign div_t   = {rem_ff, lo_ff[DIV_BITS-1]};
   assign div_sub = div_t - {1'b0, dvs_ff};
   assign div_ge  = (div_t >= {1'b0, dvs_ff});

   always_comb begin
      unique case (uw.cond)
         CD_NEVER:      jump = 1'b0;
         CD_ALWAYS:     jump = 1'b1;
         CD_NO_REQ:     jump = !req_fire;
         CD_NO_RESCALE: jump = !rescale;
         CD_ITER_MORE:  jump = (iter_ff != '0);
         CD_RSP_BUSY:   jump = rsp_busy;
         default:       jump = 1'b0;
      endcase
      pc_in = jump ? uw.target : pc_ff + PC_BITS'(1);
   end

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      rise_in      = rise_ff;
      fall_in      = fall_ff;
      hold_in      = hold_ff;
      dt_in        = dt_ff;
      en_in        = en_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      lo_in        = lo_ff;
      iter_in      = iter_ff;
      sat_in       = sat_ff;
      rsp_level_in = rsp_level_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_RISE_TIME: rise_in = csr_data;
            CSR_FALL_TIME: fall_in = csr_data;
            CSR_MIN_HOLD:  hold_in = csr_data;
            default: ;
         endcase
      end

      if (req_fire) begin
         dt_in = req_tdata[DT_BITS-1:0];
         en_in = req_tdata[DT_BITS];
      end

      unique case (uw.op)
         OP_STEP: begin
            unique case (phase_ff) inside
               PH_OFF, PH_RISE: begin
                  if (en_ff) begin
                     if (sum_c >= rl_s) begin
                        phase_in = PH_ON;
                        count_in = $signed(CNT_BITS'(hold_ff));
                     end else begin
                        phase_in = PH_RISE;
                        count_in = sum_c;
                     end
                  end
               end
               PH_ON: begin
                  if (en_ff) begin
                     if (!count_ff[CNT_BITS-1]) begin
                        count_in = diff_c;
                     end
                  end else if (diff_c[CNT_BITS-1]) begin
                     phase_in = PH_FALL;
                     count_in = $signed(CNT_BITS'(fall_ff));
                  end else begin
                     count_in = diff_c;
                  end
               end
               PH_FALL: begin
                  if (!en_ff) begin
                     count_in = diff_c;
                     if (diff_c[CNT_BITS-1]) begin
                        phase_in = PH_OFF;
                     end
                  end
               end
               default: ;
            endcase
         end
         OP_MUL: begin
            prod_in = (2*TIME_BITS)'(clamp_from) * (2*TIME_BITS)'(to_len);
            dvs_in  = from_len;
         end
         OP_RLOAD: begin
            rem_in  = prod_ff[2*TIME_BITS-1:TIME_BITS];
            lo_in   = DIV_BITS'(prod_ff[TIME_BITS-1:0]) << LO_SHIFT;
            iter_in = ITER_BITS'(TIME_BITS - 1);
         end
         OP_DIV: begin
            rem_in  = div_ge ? div_sub[TIME_BITS-1:0] : div_t[TIME_BITS-1:0];
            lo_in   = {lo_ff[DIV_BITS-2:0], div_ge};
            iter_in = iter_ff - ITER_BITS'(1);
         end
         OP_RSET: begin
            count_in = $signed(CNT_BITS'(lo_ff[TIME_BITS-1:0]));
            phase_in = (phase_ff == PH_RISE) ? PH_FALL : PH_RISE;
         end
         OP_LLOAD: begin
            rem_in  = clamp_cur;
            sat_in  = (clamp_cur == cur_len);
            dvs_in  = cur_len;
            lo_in   = '0;
            iter_in = ITER_BITS'(LEVEL_BITS - 1);
         end
         OP_EMIT: begin
            if (!rsp_busy) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = phase_ff;
               unique case (phase_ff) inside
                  PH_OFF:           rsp_level_in = '0;
                  PH_ON:            rsp_level_in = '1;
                  PH_RISE, PH_FALL: rsp_level_in = sat_ff ? '1 : lo_ff[LEVEL_BITS-1:0];
                  default:          rsp_level_in = '0;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_WAIT;
         phase_ff     <= PH_OFF;
         count_ff     <= '0;
         rise_ff      <= TIME_BITS'(1000);
         fall_ff      <= TIME_BITS'(1000);
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dt_ff        <= dt_in;
      en_ff        <= en_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      lo_ff        <= lo_in;
      iter_ff      <= iter_in;
      sat_ff       <= sat_in;
      rsp_level_ff <= rsp_level_in;
      rsp_phase_ff <= rsp_phase_in;
   end

`ifndef SYNTHESIS
   a_accept_to_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (pc_ff == PC_STEP))
      else $error("accepted word did not start the update step");

   a_rescale_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_RDIV) |-> (rem_ff < dvs_ff))
      else $error("rescale divider remainder out of range");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(pc_ff) == PC_EMIT))
      else $error("result raised outside the emit step");

   a_on_full_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_phase_ff == PH_ON)) |-> (rsp_level_ff == '1))
      else $error("level not full while on");

   a_off_zero_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_phase_ff == PH_OFF)) |-> (rsp_level_ff == '0))
      else $error("level not zero while off");
`endif

endmodule

// File: dv/fade_envelope_with_min_hold_unit_tb.sv
// Testbench for fade_envelope_with_min_hold_unit: ticks drive the envelope, an in-bench
// predictor forms the expected level word, and a checker compares every output word.
// Depends on fenv_pkg and the unit RTL only.
`timescale 1ns / 100ps

module fade_envelope_with_min_hold_unit_tb
   import fenv_pkg::*;
();

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_type;

   typedef struct {
      logic [LEVEL_BITS-1:0] level;
      phase_type             phase;
      logic                  off;
   } level_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_BITS-1:0]     req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]     rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [TIME_BITS-1:0]    csr_data = '0;

   // predictor state and register copies
   logic [TIME_BITS-1:0] rise_reg = 24'd1000;
   logic [TIME_BITS-1:0] fall_reg = 24'd1000;
   logic [TIME_BITS-1:0] hold_reg = 24'd0;
   phase_type            env_phase = PH_OFF;
   longint               env_count = 0;

   level_word_type pending_levels[$];
   int error_count = 0;
   int tick_count = 0;
   int word_count = 0;
   int csr_count = 0;
   int cycle_count = 0;

   rx_mode_type rx_mode = RX_ALWAYS;
   int hold_ticket = 0;
   int hold_served = 0;
   int hold_left = 0;
   bit gaps_on = 1'b0;
   int burst_left = 1;

   fade_envelope_with_min_hold_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("fade_envelope_with_min_hold_unit_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint clamped(input longint c, input longint len);
      if (c < 0) return 0;
      if (c > len) return len;
      return c;
   endfunction

   function automatic longint rescaled(input longint c, input longint from_len,
                                       input longint to_len);
      return (clamped(c, from_len) * to_len) / from_len;
   endfunction

   function automatic logic [LEVEL_BITS-1:0] ramp_fraction(input longint c,
                                                          input longint len);
      longint v;
      v = (clamped(c, len) << LEVEL_BITS) / len;
      if (v >= (longint'(1) << LEVEL_BITS)) return '1;
      return v[LEVEL_BITS-1:0];
   endfunction

   function automatic level_word_type advance_envelope(input logic [DT_BITS-1:0] elapsed,
                                                       input logic enable);
      longint rl;
      longint fl;
      longint dt;
      level_word_type w;
      rl = (rise_reg == 0) ? 1 : longint'(rise_reg);
      fl = (fall_reg == 0) ? 1 : longint'(fall_reg);
      dt = longint'(elapsed);
      if (env_phase == PH_OFF && enable) begin
         env_count = 0;
         env_phase = PH_RISE;
      end
      case (env_phase)
         PH_RISE: begin
            if (!enable) begin
               env_count = rescaled(env_count, rl, fl);
               env_phase = PH_FALL;
            end else begin
               env_count += dt;
               if (env_count >= rl) begin
                  env_count = longint'(hold_reg);
                  env_phase = PH_ON;
               end
            end
         end
         PH_ON: begin
            if (enable) begin
               if (env_count >= 0) env_count -= dt;
            end else begin
               env_count -= dt;
               if (env_count < 0) begin
                  env_count = longint'(fall_reg);
                  env_phase = PH_FALL;
               end
            end
         end
         PH_FALL: begin
            if (enable) begin
               env_count = rescaled(env_count, fl, rl);
               env_phase = PH_RISE;
            end else begin
               env_count -= dt;
               if (env_count < 0) env_phase = PH_OFF;
            end
         end
         default: ;
      endcase
      case (env_phase)
         PH_OFF:  w.level = '0;
         PH_ON:   w.level = '1;
         PH_RISE: w.level = ramp_fraction(env_count, rl);
         default: w.level = ramp_fraction(env_count, fl);
      endcase
      w.phase = env_phase;
      w.off = (env_phase == PH_OFF);
      return w;
   endfunction

   // ---------------------------------------------------------------- checker
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s on word %0d: got %0d want %0d", what, word_count, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_words
      level_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_levels.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            want = pending_levels.pop_front();
            if (rsp_tdata[LEVEL_BITS-1:0] !== want.level)
               report_mismatch("level", rsp_tdata[LEVEL_BITS-1:0], want.level);
            if (rsp_tdata[LEVEL_BITS+1:LEVEL_BITS] !== want.phase)
               report_mismatch("phase", rsp_tdata[LEVEL_BITS+1:LEVEL_BITS], want.phase);
            if (rsp_tdata[LEVEL_BITS+2] !== want.off)
               report_mismatch("is_off", rsp_tdata[LEVEL_BITS+2], want.off);
         end
         word_count++;
      end
   end

   // receiver: stall pattern plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_ticket != hold_served) begin
         hold_served <= hold_ticket;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_tready <= ((cycle_count % 7) >= 3);
            default:     rsp_tready <= 1'b1;
         endcase
      end
   end

   // ---------------------------------------------------------------- drivers
   task automatic send_tick(input logic [DT_BITS-1:0] elapsed, input logic enable);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_BITS'({enable, elapsed});
      do @(posedge clock); while (!req_tready);
      pending_levels.push_back(advance_envelope(elapsed, enable));
      tick_count++;
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 20);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   task automatic write_regs(input logic [TIME_BITS-1:0] rise, input logic [TIME_BITS-1:0] fall,
                             input logic [TIME_BITS-1:0] hold);
      logic [TIME_BITS-1:0] vals[3];
      logic [CSR_IDX_BITS-1:0] idx[3];
      vals = '{rise, fall, hold};
      idx = '{CSR_RISE_TIME, CSR_FALL_TIME, CSR_MIN_HOLD};
      wait_drained();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_RISE_TIME: rise_reg = vals[i];
            CSR_FALL_TIME: fall_reg = vals[i];
            default:       hold_reg = vals[i];
         endcase
         csr_count++;
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DT_BITS-1:0] pick_elapsed();
      longint span;
      int r;
      span = longint'(rise_reg > fall_reg ? rise_reg : fall_reg) / 6 + 1;
      if (span > 65535) span = 65535;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return DT_BITS'($urandom);
      return DT_BITS'($urandom_range(0, int'(span)));
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      gaps_on = 1'b0;
      rx_mode = RX_RANDOM;
      // reset registers: off, rise, reversals both ways, hold, drop to off
      send_tick(16'd0, 1'b0);
      send_tick(16'hFFFF, 1'b0);
      send_tick(16'd0, 1'b1);
      send_tick(16'd300, 1'b1);
      send_tick(16'd0, 1'b0);
      send_tick(16'd100, 1'b0);
      send_tick(16'd0, 1'b1);
      send_tick(16'hFFFF, 1'b1);
      send_tick(16'd0, 1'b1);
      send_tick(16'd1, 1'b1);
      send_tick(16'd5, 1'b1);
      send_tick(16'd0, 1'b0);
      send_tick(16'd999, 1'b0);
      send_tick(16'd2, 1'b0);
      // zero ramp times act as one
      write_regs(24'd0, 24'd0, 24'd5);
      send_tick(16'd0, 1'b1);
      send_tick(16'd1, 1'b1);
      send_tick(16'd3, 1'b0);
      send_tick(16'd3, 1'b0);
      send_tick(16'd0, 1'b1);
      send_tick(16'd0, 1'b0);
      send_tick(16'hFFFF, 1'b0);
      // full-scale registers, then retime mid-ramp
      write_regs(TIME_MAX, TIME_MAX, TIME_MAX);
      send_tick(16'hFFFF, 1'b1);
      send_tick(16'hFFFF, 1'b1);
      send_tick(16'd0, 1'b0);
      write_regs(24'd10, 24'd20, 24'd3);
      send_tick(16'd0, 1'b0);
      send_tick(16'hFFFF, 1'b0);
   endtask

   task automatic test_random_runs();
      logic en_state;
      int run_left;
      logic en;
      en_state = 1'b0;
      run_left = 0;
      for (int p = 0; p < 9; p++) begin
         case (p)
            3:       write_regs(TIME_MAX, TIME_MAX, TIME_MAX);
            5:       write_regs(24'd1, 24'd1, 24'd0);
            7:       write_regs(24'($urandom_range(1, 60)), 24'($urandom_range(1, 60)),
                                24'($urandom_range(0, 60)));
            default: write_regs(24'($urandom_range(1, 4000)), 24'($urandom_range(1, 4000)),
                                24'($urandom_range(0, 3000)));
         endcase
         rx_mode = rx_mode_type'(p % 3);
         gaps_on = (p % 4 != 1);
         for (int i = 0; i < 160; i++) begin
            if (run_left == 0) begin
               en_state = !en_state;
               run_left = $urandom_range(1, 30);
            end
            run_left--;
            en = ($urandom_range(0, 11) == 0) ? !en_state : en_state;
            send_tick(pick_elapsed(), en);
         end
      end
   endtask

   task automatic test_backpressure();
      write_regs(24'd500, 24'd700, 24'd200);
      gaps_on = 1'b0;
      rx_mode = RX_PERIODIC;
      for (int k = 0; k < 2; k++) begin
         hold_ticket++;
         for (int i = 0; i < 30; i++)
            send_tick(DT_BITS'($urandom_range(0, 150)), 1'(i < 18));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_runs();
      test_backpressure();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d ticks, %0d words checked, %0d register writes",
               tick_count, word_count, csr_count);
      $display("stall patterns, sender bursts and long receiver hold-offs exercised");
      if (error_count == 0 && pending_levels.size() == 0) begin
         $display("fade_envelope_with_min_hold_unit_tb: clean");
      end else begin
         $display("fade_envelope_with_min_hold_unit_tb: errors");
      end
      $finish;
   end

endmodule
